// ===== design/efrs_pkg.sv =====
package efrs_pkg;

   localparam int HEADER_LEN = 4;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1
   } phase_type;

   typedef enum logic [1:0] {
      K_HEADER  = 2'd0,
      K_PAYLOAD = 2'd1,
      K_OK      = 2'd2,
      K_ERROR   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_LENGTH   = 2'd1,
      ERR_TRAILING = 2'd2
   } err_type;

   // one result as it leaves the block
   typedef struct packed {
      kind_type    kind;
      logic [15:0] field_id;
      logic [15:0] field_len;
      logic [7:0]  payload_byte;
      logic        payload_end;
      err_type     error_code;
      logic        run_last;
   } result_type;

   // one queued input byte, already classified: a first result and an
   // optional closing status result
   typedef struct packed {
      kind_type    kind;
      logic [15:0] field_id;
      logic [15:0] field_len;
      logic [7:0]  payload_byte;
      logic        payload_end;
      err_type     error_code;
      logic        has_second;
      kind_type    second_kind;
      err_type     second_err;
   } entry_type;

endpackage

// ===== design/efrs_front.sv =====
module efrs_front
   import efrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   input  logic        in_final,
   input  logic        full,
   output logic        push,
   output entry_type   entry
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  count_ff, count_in;
   logic [23:0] hbytes_ff, hbytes_in;
   logic [15:0] remain_ff, remain_in;
   logic        nonzero_ff, nonzero_in;

   logic        accept;
   logic [15:0] remain_dec;
   logic        rec_end;
   logic [15:0] hdr_len;
   logic        bad_trail;

   assign accept     = in_valid && !full;
   assign remain_dec = remain_ff - 16'd1;
   assign rec_end    = (remain_dec == 16'd0);
   assign hdr_len    = {in_byte, hbytes_ff[23:16]};
   assign bad_trail  = nonzero_ff || (in_byte != 8'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         count_ff   <= 2'd0;
         remain_ff  <= 16'd0;
         nonzero_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         remain_ff  <= remain_in;
         nonzero_ff <= nonzero_in;
      end
   end

   always_ff @(posedge clock) begin
      hbytes_ff <= hbytes_in;
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      hbytes_in  = hbytes_ff;
      remain_in  = remain_ff;
      nonzero_in = nonzero_ff;
      push       = 1'b0;
      entry      = '0;
      entry.kind        = K_HEADER;
      entry.error_code  = ERR_NONE;
      entry.second_kind = K_OK;
      entry.second_err  = ERR_NONE;

      if (accept) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               push               = 1'b1;
               entry.kind         = K_PAYLOAD;
               entry.payload_byte = in_byte;
               entry.payload_end  = rec_end;
               entry.has_second   = in_final;
               entry.second_kind  = rec_end ? K_OK : K_ERROR;
               entry.second_err   = rec_end ? ERR_NONE : ERR_LENGTH;
               remain_in          = remain_dec;
               if (rec_end) begin
                  phase_in   = PH_HEADER;
                  count_in   = 2'd0;
                  nonzero_in = 1'b0;
               end
            end
            default: begin
               if (count_ff == 2'(HEADER_LEN - 1)) begin
                  push              = 1'b1;
                  entry.kind        = K_HEADER;
                  entry.field_id    = hbytes_ff[15:0];
                  entry.field_len   = hdr_len;
                  entry.has_second  = in_final;
                  entry.second_kind = (hdr_len == 16'd0) ? K_OK : K_ERROR;
                  entry.second_err  = (hdr_len == 16'd0) ? ERR_NONE : ERR_LENGTH;
                  count_in          = 2'd0;
                  nonzero_in        = 1'b0;
                  remain_in         = hdr_len;
                  phase_in          = (hdr_len != 16'd0) ? PH_PAYLOAD : PH_HEADER;
               end else begin
                  case (count_ff)
                     2'd0:    hbytes_in[7:0]   = in_byte;
                     2'd1:    hbytes_in[15:8]  = in_byte;
                     default: hbytes_in[23:16] = in_byte;
                  endcase
                  count_in   = count_ff + 2'd1;
                  nonzero_in = bad_trail;
                  if (in_final) begin
                     push             = 1'b1;
                     entry.kind       = bad_trail ? K_ERROR : K_OK;
                     entry.error_code = bad_trail ? ERR_TRAILING : ERR_NONE;
                  end
               end
            end
         endcase

         // restart for the next area
         if (in_final) begin
            phase_in   = PH_HEADER;
            count_in   = 2'd0;
            remain_in  = 16'd0;
            nonzero_in = 1'b0;
         end
      end
   end

endmodule

// ===== design/efrs_queue.sv =====
module efrs_queue
   import efrs_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   localparam int AW = $clog2(DEPTH);

   entry_type         mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]       count_ff;
   logic              do_push, do_pop;

   assign full    = (count_ff == (AW + 1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   push_not_full_a: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   count_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW + 1)'(DEPTH))
      else $error("queue count out of range");

   pop_moves_a: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on read");

endmodule

// ===== design/efrs_back.sv =====
module efrs_back
   import efrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  entry_type  head,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_result
);

   logic       valid_ff;
   result_type result_ff, result_in;
   logic       pending_ff, pending_in;
   kind_type   sec_kind_ff, sec_kind_in;
   err_type    sec_err_ff, sec_err_in;
   logic       slot_free;
   logic       load;

   assign slot_free  = !valid_ff || !out_stall;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      pop         = 1'b0;
      load        = 1'b0;
      result_in   = result_ff;
      pending_in  = pending_ff;
      sec_kind_in = sec_kind_ff;
      sec_err_in  = sec_err_ff;
      if (slot_free) begin
         if (pending_ff) begin
            // emit the closing status of the held byte
            load                   = 1'b1;
            result_in              = '0;
            result_in.kind         = sec_kind_ff;
            result_in.error_code   = sec_err_ff;
            result_in.run_last     = 1'b1;
            pending_in             = 1'b0;
         end else if (!empty) begin
            pop                    = 1'b1;
            load                   = 1'b1;
            result_in.kind         = head.kind;
            result_in.field_id     = head.field_id;
            result_in.field_len    = head.field_len;
            result_in.payload_byte = head.payload_byte;
            result_in.payload_end  = head.payload_end;
            result_in.error_code   = head.error_code;
            result_in.run_last     = !head.has_second;
            pending_in             = head.has_second;
            sec_kind_in            = head.second_kind;
            sec_err_in             = head.second_err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         if (slot_free) begin
            valid_ff <= load;
         end
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff   <= result_in;
      sec_kind_ff <= sec_kind_in;
      sec_err_ff  <= sec_err_in;
   end

   pending_has_first_a: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> valid_ff)
      else $error("status pending without its first result");

   no_pop_when_pending_a: assert property (@(posedge clock) disable iff (reset)
      pop |-> !pending_ff)
      else $error("queue read while a status result is pending");

   status_is_last_a: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (result_ff.kind == K_OK || result_ff.kind == K_ERROR))
         |-> result_ff.run_last)
      else $error("status result not marked last");

endmodule

// ===== design/extra_field_record_splitter.sv =====
// Splits a ZIP extra-field area, one byte per transfer with the final byte
// marked, into id/length record headers, payload bytes and a closing
// success or error status. One byte is taken every cycle while the internal
// queue (QUEUE_DEPTH entries) has room; the first result of a byte passes
// through the queue and then the output register. The output register issues
// one result per cycle while the consumer does not stall, so a final byte that
// also completes a header or carries a payload byte yields two results; bytes
// that complete nothing yield no result. On an error status the consumer drops
// every record already issued for the area.
module extra_field_record_splitter
   import efrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_field_id,
   output logic [15:0] rsp_field_len,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_end,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_run_last
);

   logic       push, pop, full, empty;
   entry_type  push_entry, head;
   result_type result;

   assign req_stall = full;

   efrs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_byte  (req_in_byte),
      .in_final (req_final_byte),
      .full     (full),
      .push     (push),
      .entry    (push_entry)
   );

   efrs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   efrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (result)
   );

   assign rsp_kind         = result.kind;
   assign rsp_field_id     = result.field_id;
   assign rsp_field_len    = result.field_len;
   assign rsp_payload_byte = result.payload_byte;
   assign rsp_payload_end  = result.payload_end;
   assign rsp_error_code   = result.error_code;
   assign rsp_run_last     = result.run_last;

endmodule

// ===== bench/extra_field_record_splitter_tb.sv =====
module extra_field_record_splitter_tb;
   import efrs_pkg::*;

   localparam int DIRECTED_ROWS = 26;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int QUIET_FIRST   = 300;
   localparam int QUIET_LAST    = 600;
   localparam int DRAIN_CYCLES  = 20;

   localparam result_type NO_RESULT  = '0;
   localparam result_type OK_LAST    =
      '{K_OK, 16'h0000, 16'h0000, 8'h00, 1'b0, ERR_NONE, 1'b1};
   localparam result_type TRAIL_LAST =
      '{K_ERROR, 16'h0000, 16'h0000, 8'h00, 1'b0, ERR_TRAILING, 1'b1};
   localparam result_type LEN_LAST   =
      '{K_ERROR, 16'h0000, 16'h0000, 8'h00, 1'b0, ERR_LENGTH, 1'b1};
   localparam result_type HDR_ZERO   =
      '{K_HEADER, 16'h0000, 16'h0000, 8'h00, 1'b0, ERR_NONE, 1'b1};
   localparam result_type HDR_MAX    =
      '{K_HEADER, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0, ERR_NONE, 1'b0};

   typedef struct {
      logic [7:0] data;
      logic       fin;
      bit         typed;
      int         count;
      result_type first;
      result_type second;
   } area_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } area_byte_type;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte    = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_field_id;
   logic [15:0] rsp_field_len;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_end;
   logic [1:0]  rsp_error_code;
   logic        rsp_run_last;

   extra_field_record_splitter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_field_id     (rsp_field_id),
      .rsp_field_len    (rsp_field_len),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_end  (rsp_payload_end),
      .rsp_error_code   (rsp_error_code),
      .rsp_run_last     (rsp_run_last)
   );

   // splitter state as seen by the predictor
   phase_type   split_phase = PH_HEADER;
   logic [2:0]  hdr_count   = 3'd0;
   logic [31:0] hdr_bytes   = 32'h0;
   logic [15:0] body_left   = 16'h0;
   logic        hdr_nonzero = 1'b0;

   result_type     expected_results[$];
   area_row_type   directed_rows[DIRECTED_ROWS];
   area_byte_type  stream[$];
   bit             quiet = 1'b0;
   int             errors = 0;
   int             bytes_sent = 0;
   int             areas_sent = 0;
   int             results_seen = 0;
   int             kind_seen[4] = '{0, 0, 0, 0};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic split_byte(input logic [7:0] data, input logic fin, input bit keep);
      result_type  res[2];
      int          n;
      logic [15:0] left;
      logic [1:0]  slot;
      logic [15:0] len;
      n = 0;
      res[0] = '0;
      res[1] = '0;
      if (split_phase == PH_PAYLOAD) begin
         left = body_left - 16'd1;
         res[0].kind = K_PAYLOAD;
         res[0].payload_byte = data;
         res[0].payload_end = (left == 16'd0);
         n = 1;
         body_left = left;
         if (left == 16'd0) begin
            split_phase = PH_HEADER;
            hdr_count = 3'd0;
            hdr_bytes = 32'h0;
            hdr_nonzero = 1'b0;
         end
         if (fin) begin
            res[1].kind = (left == 16'd0) ? K_OK : K_ERROR;
            res[1].error_code = (left == 16'd0) ? ERR_NONE : ERR_LENGTH;
            n = 2;
         end
      end else begin
         slot = hdr_count[1:0];
         hdr_bytes[slot*8 +: 8] = data;
         if (data != 8'h00) hdr_nonzero = 1'b1;
         hdr_count = {1'b0, slot} + 3'd1;
         if (hdr_count == 3'(HEADER_LEN)) begin
            len = hdr_bytes[31:16];
            res[0].kind = K_HEADER;
            res[0].field_id = hdr_bytes[15:0];
            res[0].field_len = len;
            n = 1;
            hdr_count = 3'd0;
            hdr_bytes = 32'h0;
            hdr_nonzero = 1'b0;
            body_left = len;
            split_phase = (len != 16'd0) ? PH_PAYLOAD : PH_HEADER;
            if (fin) begin
               res[1].kind = (len == 16'd0) ? K_OK : K_ERROR;
               res[1].error_code = (len == 16'd0) ? ERR_NONE : ERR_LENGTH;
               n = 2;
            end
         end else if (fin) begin
            // leftover bytes short of a header: zeros are padding, anything else is garbage
            res[0].kind = hdr_nonzero ? K_ERROR : K_OK;
            res[0].error_code = hdr_nonzero ? ERR_TRAILING : ERR_NONE;
            n = 1;
         end
      end
      if (fin) begin
         split_phase = PH_HEADER;
         hdr_count = 3'd0;
         hdr_bytes = 32'h0;
         body_left = 16'h0;
         hdr_nonzero = 1'b0;
      end
      if (n > 0) res[n-1].run_last = 1'b1;
      if (keep) begin
         for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
      end
   endtask

   task automatic send_byte(input logic [7:0] data, input logic fin);
      while (!quiet && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= data;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (fin) areas_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_sink
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            kind_seen[rsp_kind]++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result kind %h expected none actual %h",
                        $time, rsp_kind, rsp_kind);
               errors++;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_kind));
               check_field("field_id", want.field_id, rsp_field_id);
               check_field("field_len", want.field_len, rsp_field_len);
               check_field("payload_byte", 16'(want.payload_byte), 16'(rsp_payload_byte));
               check_field("payload_end", 16'(want.payload_end), 16'(rsp_payload_end));
               check_field("error_code", 16'(want.error_code), 16'(rsp_error_code));
               check_field("run_last", 16'(want.run_last), 16'(rsp_run_last));
            end
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 20);
      end
   end

   initial begin : stimulus
      logic [7:0]  area[$];
      logic [15:0] id;
      logic [15:0] len;
      int          mode;
      int          nrec;
      int          nbody;
      int          cut;
      int          trail;
      int          drain_at;
      int          guard;
      drain_at = -1;

      directed_rows = '{
         '{8'h00, 1'b1, 1'b1, 1, OK_LAST,    NO_RESULT},  // lone zero pad
         '{8'h80, 1'b1, 1'b1, 1, TRAIL_LAST, NO_RESULT},  // lone nonzero pad
         '{8'h00, 1'b0, 1'b1, 0, NO_RESULT,  NO_RESULT},
         '{8'h01, 1'b1, 1'b1, 1, TRAIL_LAST, NO_RESULT},
         '{8'h00, 1'b0, 1'b1, 0, NO_RESULT,  NO_RESULT},  // four zeros form a header
         '{8'h00, 1'b0, 1'b1, 0, NO_RESULT,  NO_RESULT},
         '{8'h00, 1'b0, 1'b1, 0, NO_RESULT,  NO_RESULT},
         '{8'h00, 1'b0, 1'b1, 1, HDR_ZERO,   NO_RESULT},
         '{8'h34, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'h12, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'h01, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'h00, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'hFF, 1'b1, 1'b0, 0, NO_RESULT,  NO_RESULT},  // payload closes the area
         '{8'h07, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'h00, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'h00, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'h00, 1'b1, 1'b0, 0, NO_RESULT,  NO_RESULT},  // empty record on final byte
         '{8'hFF, 1'b0, 1'b1, 0, NO_RESULT,  NO_RESULT},
         '{8'hFF, 1'b0, 1'b1, 0, NO_RESULT,  NO_RESULT},
         '{8'hFF, 1'b0, 1'b1, 0, NO_RESULT,  NO_RESULT},
         '{8'hFF, 1'b1, 1'b1, 2, HDR_MAX,    LEN_LAST},   // header ends area, body missing
         '{8'h02, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'h00, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'h03, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'h00, 1'b0, 1'b0, 0, NO_RESULT,  NO_RESULT},
         '{8'hAA, 1'b1, 1'b0, 0, NO_RESULT,  NO_RESULT}   // area ends inside a body
      };

      // mostly well-formed areas, some cut short, some pure noise
      while (stream.size() < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         area.delete();
         if (mode == 9) begin
            nbody = $urandom_range(1, 10);
            repeat (nbody) area.push_back(8'($urandom));
         end else begin
            nrec = $urandom_range(0, 3);
            for (int k = 0; k < nrec; k++) begin
               id = 16'($urandom);
               if (mode >= 7 && k == nrec - 1) len = 16'($urandom);
               else if ($urandom_range(0, 7) == 0) len = 16'($urandom_range(8, 40));
               else len = 16'($urandom_range(0, 4));
               area.push_back(id[7:0]);
               area.push_back(id[15:8]);
               area.push_back(len[7:0]);
               area.push_back(len[15:8]);
               nbody = (len > 16'd40) ? $urandom_range(0, 5) : int'(len);
               repeat (nbody) area.push_back(8'($urandom));
            end
            if (mode >= 7) begin
               if (area.size() > 1) begin
                  cut = $urandom_range(1, area.size());
                  while (area.size() > cut) void'(area.pop_back());
               end
            end else begin
               trail = $urandom_range(0, 3);
               repeat (trail) area.push_back(8'h00);
               if (trail > 0 && $urandom_range(0, 3) == 0)
                  area[area.size() - 1 - $urandom_range(0, trail - 1)] =
                     8'($urandom_range(1, 255));
            end
            if (area.size() == 0) area.push_back(8'h00);
         end
         if (drain_at < 0 && stream.size() >= RANDOM_ITEMS / 2) drain_at = stream.size();
         foreach (area[j]) stream.push_back('{area[j], 1'(j == area.size() - 1)});
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].data, directed_rows[i].fin);
         split_byte(directed_rows[i].data, directed_rows[i].fin, !directed_rows[i].typed);
         if (directed_rows[i].typed && directed_rows[i].count > 0)
            expected_results.push_back(directed_rows[i].first);
         if (directed_rows[i].typed && directed_rows[i].count > 1)
            expected_results.push_back(directed_rows[i].second);
      end
      drain_results();

      foreach (stream[i]) begin
         quiet = (i >= QUIET_FIRST && i < QUIET_LAST);
         if (i == drain_at) drain_results();
         send_byte(stream[i].data, stream[i].fin);
         split_byte(stream[i].data, stream[i].fin, 1'b1);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      guard = 0;
      while (expected_results.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: leftover results expected 0 actual %0d", $time,
                  expected_results.size());
         errors += expected_results.size();
      end

      $display("Covered %0d bytes in %0d areas, %0d results checked:", bytes_sent,
               areas_sent, results_seen);
      $display("  %0d headers, %0d payload bytes, %0d clean ends, %0d error ends",
               kind_seen[K_HEADER], kind_seen[K_PAYLOAD], kind_seen[K_OK],
               kind_seen[K_ERROR]);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/efrs_pkg.sv
design/efrs_front.sv
design/efrs_queue.sv
design/efrs_back.sv
design/extra_field_record_splitter.sv
bench/extra_field_record_splitter_tb.sv
